>>> hw/rtl/pedal_ema_filter_pwm_map_assert.svh
// assertion macros for the pedal filter and duty map
// depends on nothing; included by the checker file
`ifndef PEDAL_EMA_FILTER_PWM_MAP_ASSERT_SVH
`define PEDAL_EMA_FILTER_PWM_MAP_ASSERT_SVH

// same-cycle implication, sampled on clk_i, quiet during reset
`define PEFPM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PEFPM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/pefpm_pkg.sv
// shared types, constants and the microprogram of the pedal filter
// no dependencies
package pefpm_pkg;

  localparam int SMP_W      = 10;
  localparam int DUTY_W     = 8;
  localparam int ALPHA_W    = 16;
  localparam int IN_W       = 10;
  localparam int CHANNELS   = 3;
  localparam int CH_W       = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int PC_W       = 4;

  localparam logic [ALPHA_W-1:0] ALPHA_RST    = 16'd19661;
  localparam logic [IN_W-1:0]    IN_LOW_RST   = 10'd188;
  localparam logic [IN_W-1:0]    IN_HIGH_RST  = 10'd460;
  localparam logic [DUTY_W-1:0]  OUT_LOW_RST  = 8'd36;
  localparam logic [DUTY_W-1:0]  OUT_HIGH_RST = 8'd112;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SMOOTHING = 3'd0,
    CFG_IN_LOW    = 3'd1,
    CFG_IN_HIGH   = 3'd2,
    CFG_OUT_LOW   = 3'd3,
    CFG_OUT_HIGH  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [SMP_W-1:0] gas_sample;
    logic [SMP_W-1:0] brake_sample;
    logic [SMP_W-1:0] clutch_sample;
  } in_item_t;

  typedef struct packed {
    logic [DUTY_W-1:0] gas_duty;
    logic [DUTY_W-1:0] brake_duty;
    logic [DUTY_W-1:0] clutch_duty;
  } out_item_t;

  typedef struct packed {
    logic [ALPHA_W-1:0] smoothing_factor;
    logic [IN_W-1:0]    in_low;
    logic [IN_W-1:0]    in_high;
    logic [DUTY_W-1:0]  out_low;
    logic [DUTY_W-1:0]  out_high;
  } cfg_t;

  // datapath operations, one per control word
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_DIFF,
    OP_MUL,
    OP_UPD,
    OP_MAPMUL,
    OP_DIVINIT,
    OP_DIVSTEP,
    OP_FIN,
    OP_OUT,
    OP_NOP
  } op_e;

  // jump conditions; a false condition falls through to the next step
  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_START,
    C_DIV_MORE,
    C_CH_MORE,
    C_OUT_FREE
  } cond_e;

  typedef struct packed {
    op_e             op;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic div_last;
    logic ch_last;
  } status_t;

  localparam logic [PC_W-1:0] PC_IDLE = 4'd0;
  localparam logic [PC_W-1:0] PC_DIFF = 4'd1;
  localparam logic [PC_W-1:0] PC_STEP = 4'd6;
  localparam logic [PC_W-1:0] PC_OUT  = 4'd8;

  // microprogram: wait for a beat, then per channel diff, scale, update, map, divide loop, finish; then output
  function automatic ctrl_t pefpm_rom(logic [PC_W-1:0] pc);
    ctrl_t w;
    unique case (pc)
      4'd0:    w = '{op: OP_IDLE,    cond: C_NO_START, target: PC_IDLE};
      4'd1:    w = '{op: OP_DIFF,    cond: C_NEXT,     target: PC_IDLE};
      4'd2:    w = '{op: OP_MUL,     cond: C_NEXT,     target: PC_IDLE};
      4'd3:    w = '{op: OP_UPD,     cond: C_NEXT,     target: PC_IDLE};
      4'd4:    w = '{op: OP_MAPMUL,  cond: C_NEXT,     target: PC_IDLE};
      4'd5:    w = '{op: OP_DIVINIT, cond: C_NEXT,     target: PC_IDLE};
      4'd6:    w = '{op: OP_DIVSTEP, cond: C_DIV_MORE, target: PC_STEP};
      4'd7:    w = '{op: OP_FIN,     cond: C_CH_MORE,  target: PC_DIFF};
      4'd8:    w = '{op: OP_OUT,     cond: C_OUT_FREE, target: PC_IDLE};
      4'd9:    w = '{op: OP_NOP,     cond: C_ALWAYS,   target: PC_OUT};
      default: w = '{op: OP_NOP,     cond: C_ALWAYS,   target: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

>>> hw/rtl/pefpm_seq.sv
// step counter and control store of the pedal filter
// depends on pefpm_pkg
module pefpm_seq
  import pefpm_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    out_free_i,
  input  status_t status_i,
  output ctrl_t   ctrl_o
);

  logic [PC_W-1:0] pc_q, pc_d;
  ctrl_t           word;
  logic            take;

  assign word   = pefpm_rom(pc_q);
  assign ctrl_o = word;

  always_comb begin
    unique case (word.cond)
      C_NEXT:     take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NO_START: take = !in_valid_i;
      C_DIV_MORE: take = !status_i.div_last;
      C_CH_MORE:  take = !status_i.ch_last;
      C_OUT_FREE: take = out_free_i;
      default:    take = 1'b1;
    endcase
    pc_d = take ? word.target : pc_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

>>> hw/rtl/pefpm_datapath.sv
// averaging, scaling and division datapath, driven by the control word
// depends on pefpm_pkg
module pefpm_datapath
  import pefpm_pkg::*;
#(
  parameter int SAMPLE_BITS   = 10,
  parameter int FRACTION_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ctrl_t     ctrl_i,
  input  logic      start_i,
  input  in_item_t  in_data_i,
  input  cfg_t      cfg_i,
  output status_t   status_o,
  output out_item_t duty_o
);

  localparam int AVG_W = SAMPLE_BITS + FRACTION_BITS;
  localparam int SXW   = (SAMPLE_BITS > SMP_W) ? SAMPLE_BITS : SMP_W;
  localparam int XW    = SXW + 1;
  localparam int DY_W  = DUTY_W + 1;
  localparam int NUM_W = XW + DY_W;
  localparam int DEN_W = IN_W + 1;
  localparam int RW    = NUM_W + 2;
  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam logic [SXW-1:0] SAMPLE_MAX = SXW'((1 << SAMPLE_BITS) - 1);

  logic [SAMPLE_BITS-1:0]   smp_q [CHANNELS];
  logic [AVG_W-1:0]         avg_q [CHANNELS];
  logic [DUTY_W-1:0]        res_q [CHANNELS];
  logic [CH_W-1:0]          ch_q;
  logic [AVG_W-1:0]         mag_q;
  logic                     up_q;
  logic [AVG_W+ALPHA_W-1:0] prod_q;
  logic signed [NUM_W-1:0]  num_q;
  logic signed [DEN_W-1:0]  den_q;
  logic [NUM_W-1:0]         quo_q;
  logic [DEN_W-1:0]         rem_q, dvs_q;
  logic                     qneg_q;
  logic [CNT_W-1:0]         cnt_q;

  logic [SXW-1:0]          raw [CHANNELS];
  logic [AVG_W-1:0]        cur_avg, s_wide, step, avg_new;
  logic [SAMPLE_BITS-1:0]  x;
  logic signed [XW-1:0]    dx;
  logic signed [DY_W-1:0]  dy;
  logic signed [NUM_W-1:0] num;
  logic signed [DEN_W-1:0] den;
  logic [DEN_W-1:0]        trial;
  logic                    ge;
  logic signed [RW-1:0]    qs, r;
  logic [DUTY_W-1:0]       duty;

  assign raw[0] = SXW'(in_data_i.gas_sample);
  assign raw[1] = SXW'(in_data_i.brake_sample);
  assign raw[2] = SXW'(in_data_i.clutch_sample);

  always_comb begin
    cur_avg = avg_q[ch_q];
    s_wide  = {smp_q[ch_q], FRACTION_BITS'(0)};
    step    = prod_q[ALPHA_W +: AVG_W];
    avg_new = up_q ? cur_avg + step : cur_avg - step;
    x       = cur_avg[FRACTION_BITS +: SAMPLE_BITS];
    dx      = $signed({1'b0, SXW'(x)}) - $signed({1'b0, SXW'(cfg_i.in_low)});
    dy      = $signed({1'b0, cfg_i.out_high}) - $signed({1'b0, cfg_i.out_low});
    num     = NUM_W'(dx) * NUM_W'(dy);
    den     = $signed({1'b0, cfg_i.in_high}) - $signed({1'b0, cfg_i.in_low});
    // restoring division, one quotient bit a step
    trial   = {rem_q[DEN_W-2:0], quo_q[NUM_W-1]};
    ge      = trial >= dvs_q;
    qs      = qneg_q ? -$signed(RW'(quo_q)) : $signed(RW'(quo_q));
    r       = qs + $signed(RW'(cfg_i.out_low));
    priority if (den_q == '0) begin
      duty = cfg_i.out_low;
    end else if (r < 0) begin
      duty = '0;
    end else if (r > $signed(RW'(8'hff))) begin
      duty = 8'hff;
    end else begin
      duty = r[DUTY_W-1:0];
    end
  end

  // averages are architectural state and clear on reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        avg_q[i] <= '0;
      end
      ch_q <= '0;
    end else begin
      unique case (ctrl_i.op)
        OP_IDLE: if (start_i) ch_q <= '0;
        OP_UPD:  avg_q[ch_q] <= avg_new;
        OP_FIN:  ch_q <= status_o.ch_last ? '0 : ch_q + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.op)
      OP_IDLE: begin
        if (start_i) begin
          for (int i = 0; i < CHANNELS; i++) begin
            smp_q[i] <= (raw[i] > SAMPLE_MAX) ? SAMPLE_MAX[SAMPLE_BITS-1:0]
                                              : raw[i][SAMPLE_BITS-1:0];
          end
        end
      end
      OP_DIFF: begin
        up_q  <= s_wide >= cur_avg;
        mag_q <= (s_wide >= cur_avg) ? s_wide - cur_avg : cur_avg - s_wide;
      end
      OP_MUL: prod_q <= (AVG_W + ALPHA_W)'(cfg_i.smoothing_factor) *
                        (AVG_W + ALPHA_W)'(mag_q);
      OP_MAPMUL: begin
        num_q <= num;
        den_q <= den;
      end
      OP_DIVINIT: begin
        quo_q  <= num_q[NUM_W-1] ? NUM_W'(-num_q) : NUM_W'(num_q);
        dvs_q  <= den_q[DEN_W-1] ? DEN_W'(-den_q) : DEN_W'(den_q);
        rem_q  <= '0;
        qneg_q <= num_q[NUM_W-1] ^ den_q[DEN_W-1];
        cnt_q  <= CNT_W'(NUM_W);
      end
      OP_DIVSTEP: begin
        rem_q <= ge ? trial - dvs_q : trial;
        quo_q <= {quo_q[NUM_W-2:0], ge};
        cnt_q <= cnt_q - 1'b1;
      end
      OP_FIN:  res_q[ch_q] <= duty;
      default: ;
    endcase
  end

  assign status_o.div_last = cnt_q == CNT_W'(1);
  assign status_o.ch_last  = ch_q == CH_W'(CHANNELS - 1);

  assign duty_o.gas_duty    = res_q[0];
  assign duty_o.brake_duty  = res_q[1];
  assign duty_o.clutch_duty = res_q[2];

endmodule

>>> hw/rtl/pedal_ema_filter_pwm_map.sv
// top level: pedal smoothing and pwm duty map, three channels per beat
// depends on pefpm_pkg, pefpm_seq, pefpm_datapath
//
//   channel  signals                               beat
//   in       in_valid_i  in_ready_o  in_data_i     three pedal samples
//   out      out_valid_o out_ready_i out_data_o    three pwm duties
//   cfg      cfg_valid_i cfg_ready_o cfg_index_i   one register write
//            cfg_data_i
//
// an input beat runs the channel program once per channel, then the output step;
// the restoring divider loop (NUM_W steps per channel) is its longest part
// reset clears the step counter, the three averages and the config registers
// a finished result sits in the output register, so a new beat is taken
// while the previous one still waits; the sequencer only stalls when the
// output register is still full at the end of the next beat
module pedal_ema_filter_pwm_map
  import pefpm_pkg::*;
#(
  parameter int SAMPLE_BITS   = 10,
  parameter int FRACTION_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  ctrl_t     ctrl;
  status_t   status;
  out_item_t duty;
  cfg_t      cfg_q;
  logic      out_valid_q;
  out_item_t out_q;
  logic      out_free;
  logic      in_take;

  // inputs are taken only while the program waits in its idle step
  assign in_ready_o  = ctrl.op == OP_IDLE;
  assign in_take     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;

  pefpm_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  pefpm_datapath #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .start_i   (in_take),
    .in_data_i (in_data_i),
    .cfg_i     (cfg_q),
    .status_o  (status),
    .duty_o    (duty)
  );

  // register file; writes to unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.smoothing_factor <= ALPHA_RST;
      cfg_q.in_low           <= IN_LOW_RST;
      cfg_q.in_high          <= IN_HIGH_RST;
      cfg_q.out_low          <= OUT_LOW_RST;
      cfg_q.out_high         <= OUT_HIGH_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SMOOTHING: cfg_q.smoothing_factor <= cfg_data_i[ALPHA_W-1:0];
        CFG_IN_LOW:    cfg_q.in_low           <= cfg_data_i[IN_W-1:0];
        CFG_IN_HIGH:   cfg_q.in_high          <= cfg_data_i[IN_W-1:0];
        CFG_OUT_LOW:   cfg_q.out_low          <= cfg_data_i[DUTY_W-1:0];
        CFG_OUT_HIGH:  cfg_q.out_high         <= cfg_data_i[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // output register, loaded by the final step of the program
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.op == OP_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.op == OP_OUT && out_free) begin
      out_q <= duty;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> hw/rtl/pefpm_checker.sv
// port-level checks on the pedal filter, bound into the top level
// depends on pefpm_pkg and pedal_ema_filter_pwm_map_assert.svh
`include "pedal_ema_filter_pwm_map_assert.svh"

module pefpm_checker
  import pefpm_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input out_item_t             out_data_o,
  input logic                  cfg_valid_i,
  input logic                  cfg_ready_o
);

  `PEFPM_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "out beat dropped")
  `PEFPM_ASSERT_NXT(a_out_stable, out_valid_o && !out_ready_i, $stable(out_data_o), "out beat changed")
  `PEFPM_ASSERT_NXT(a_busy_after_take, in_valid_i && in_ready_o, !in_ready_o, "beat taken while busy")
  `PEFPM_ASSERT_IMP(a_new_result_idle, $rose(out_valid_o), in_ready_o, "result without return to idle")
  `PEFPM_ASSERT_IMP(a_cfg_ready, cfg_valid_i, cfg_ready_o, "cfg write refused")

endmodule

bind pedal_ema_filter_pwm_map pefpm_checker u_pefpm_checker (.*);

>>> test/pedal_duty_checker.sv
// checker for the pedal filter: watches the three channels, predicts the duties
// depends on pefpm_pkg for the beat types, register codes and reset values
`timescale 1ns / 100ps

module pedal_duty_checker
  import pefpm_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  in_item_t              in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  out_item_t             out_data_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  localparam int AVG_W      = SMP_W + FRACTION_BITS;
  localparam int MAX_REPORT = 10;

  logic [ALPHA_W-1:0] alpha_q;
  logic [IN_W-1:0]    in_low_q;
  logic [IN_W-1:0]    in_high_q;
  logic [DUTY_W-1:0]  out_low_q;
  logic [DUTY_W-1:0]  out_high_q;

  logic [AVG_W-1:0]   gas_avg;
  logic [AVG_W-1:0]   brake_avg;
  logic [AVG_W-1:0]   clutch_avg;

  out_item_t          duty_due_q[$];
  out_item_t          want;

  // moves one average toward the widened sample by alpha of the distance
  function automatic logic [AVG_W-1:0] ema_step(input logic [AVG_W-1:0] avg,
                                                input logic [SMP_W-1:0] smp);
    logic [AVG_W-1:0]         target;
    logic [AVG_W-1:0]         span;
    logic [AVG_W+ALPHA_W-1:0] prod;
    logic [AVG_W-1:0]         delta;
    target = {smp, {FRACTION_BITS{1'b0}}};
    span   = (target >= avg) ? target - avg : avg - target;
    prod   = alpha_q * span;
    delta  = prod[AVG_W+ALPHA_W-1:ALPHA_W];
    return (target >= avg) ? avg + delta : avg - delta;
  endfunction

  // signed linear map of the integer part, truncating quotient, clamped duty
  function automatic logic [DUTY_W-1:0] duty_map(input logic [AVG_W-1:0] avg);
    longint x;
    longint span_in;
    longint r;
    x       = longint'(avg[AVG_W-1:FRACTION_BITS]);
    span_in = longint'(in_high_q) - longint'(in_low_q);
    if (span_in == 0) return out_low_q;
    r = ((x - longint'(in_low_q)) * (longint'(out_high_q) - longint'(out_low_q))) / span_in
        + longint'(out_low_q);
    if (r < 0) r = 0;
    if (r > 255) r = 255;
    return r[DUTY_W-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q      = ALPHA_RST;
      in_low_q     = IN_LOW_RST;
      in_high_q    = IN_HIGH_RST;
      out_low_q    = OUT_LOW_RST;
      out_high_q   = OUT_HIGH_RST;
      gas_avg      = '0;
      brake_avg    = '0;
      clutch_avg   = '0;
      duty_due_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // results first: a beat cannot come out in the cycle its input goes in
      if (out_valid_i && out_ready_i) begin
        if (duty_due_q.size() == 0) begin
          if (fail_count_o < MAX_REPORT) begin
            $display("%0t: duty beat with none due: gas %0d brake %0d clutch %0d", $time,
                     out_data_i.gas_duty, out_data_i.brake_duty, out_data_i.clutch_duty);
          end
          fail_count_o++;
        end else begin
          want = duty_due_q.pop_front();
          if (out_data_i.gas_duty !== want.gas_duty ||
              out_data_i.brake_duty !== want.brake_duty ||
              out_data_i.clutch_duty !== want.clutch_duty) begin
            if (fail_count_o < MAX_REPORT) begin
              $display("%0t: duty mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                       $time, want.gas_duty, want.brake_duty, want.clutch_duty,
                       out_data_i.gas_duty, out_data_i.brake_duty, out_data_i.clutch_duty);
            end
            fail_count_o++;
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        gas_avg          = ema_step(gas_avg, in_data_i.gas_sample);
        brake_avg        = ema_step(brake_avg, in_data_i.brake_sample);
        clutch_avg       = ema_step(clutch_avg, in_data_i.clutch_sample);
        want.gas_duty    = duty_map(gas_avg);
        want.brake_duty  = duty_map(brake_avg);
        want.clutch_duty = duty_map(clutch_avg);
        duty_due_q.push_back(want);
      end

      // registers keep their low bits only, other indexes are dropped
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_SMOOTHING: alpha_q    = cfg_data_i[ALPHA_W-1:0];
          CFG_IN_LOW:    in_low_q   = cfg_data_i[IN_W-1:0];
          CFG_IN_HIGH:   in_high_q  = cfg_data_i[IN_W-1:0];
          CFG_OUT_LOW:   out_low_q  = cfg_data_i[DUTY_W-1:0];
          CFG_OUT_HIGH:  out_high_q = cfg_data_i[DUTY_W-1:0];
          default: ;
        endcase
      end

      pending_o = duty_due_q.size();
    end
  end

endmodule

>>> test/pedal_ema_filter_pwm_map_tb.sv
// top of the pedal filter testbench: clock, reset, stimulus and verdict
// depends on pefpm_pkg, pedal_ema_filter_pwm_map and pedal_duty_checker
`timescale 1ns / 100ps

module pedal_ema_filter_pwm_map_tb;
  import pefpm_pkg::*;

  localparam int SMP_MAX         = (1 << SMP_W) - 1;
  localparam int LIMIT_CYCLES    = 2_000_000;
  localparam int SETTLE_CYCLES   = 100;
  localparam int TAIL_CYCLES     = 200;
  localparam int HOLD_CYCLES     = 600;   // long enough to fill the block twice over
  localparam int RAND_PHASES     = 8;
  localparam int BEATS_PER_PHASE = 210;
  localparam int HOLD_AT         = 100;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int pending;
  int cycle_count;

  // idling knobs, in percent per beat or per cycle
  int gap_pct   = 0;
  int stall_pct = 0;
  bit hold_req  = 1'b0;

  pedal_ema_filter_pwm_map dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  pedal_duty_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 10 ns clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog: a hung handshake ends the run here
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("pedal_ema_filter_pwm_map_tb: FAIL");
    $finish;
  end

  // receiver: random stall bursts, plus one long hold-off whenever asked
  initial begin : drain
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_ready  = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready = 1'b0;
      end else begin
        out_ready = 1'b1;
        if (stall_pct > 0 && $urandom_range(1, 100) <= stall_pct) begin
          stall_left = $urandom_range(1, 8);
        end
      end
    end
  end

  function automatic in_item_t beat_of(input int g, input int b, input int c);
    in_item_t it;
    it.gas_sample    = SMP_W'(g);
    it.brake_sample  = SMP_W'(b);
    it.clutch_sample = SMP_W'(c);
    return it;
  endfunction

  // offers one input beat; called at a falling edge, returns at one with valid
  // still high so that a following beat keeps it up without a dip
  task automatic send_beat(input in_item_t it);
    if (gap_pct > 0 && $urandom_range(1, 100) <= gap_pct) begin
      in_valid = 1'b0;
      // a run of short bursts so that arrivals land anywhere in a beat
      repeat ($urandom_range(1, 10)) repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
  endtask

  // one register write; valid stays high for a write that follows
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
  endtask

  // writes every register, then a dummy write to an unused index
  task automatic set_all(input logic [CFG_DATA_W-1:0] alpha, input logic [CFG_DATA_W-1:0] il,
                         input logic [CFG_DATA_W-1:0] ih, input logic [CFG_DATA_W-1:0] ol,
                         input logic [CFG_DATA_W-1:0] oh);
    write_reg(CFG_SMOOTHING, alpha);
    write_reg(CFG_IN_LOW, il);
    write_reg(CFG_IN_HIGH, ih);
    write_reg(CFG_OUT_LOW, ol);
    write_reg(CFG_OUT_HIGH, oh);
    write_reg(CFG_IDX_W'($urandom_range(CFG_OUT_HIGH + 1, (1 << CFG_IDX_W) - 1)),
              CFG_DATA_W'($urandom_range(0, 65535)));
    cfg_valid = 1'b0;
  endtask

  // wait until every due duty has come out and the block has gone quiet
  task automatic settle();
    in_valid = 1'b0;
    wait (pending == 0);
    @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin : stimulus
    int                    level[CHANNELS];
    int                    v;
    int                    smp[CHANNELS];
    in_item_t              it;
    logic [CFG_DATA_W-1:0] alpha;
    logic [CFG_DATA_W-1:0] il;
    logic [CFG_DATA_W-1:0] ih;
    logic [CFG_DATA_W-1:0] ol;
    logic [CFG_DATA_W-1:0] oh;

    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_SMOOTHING;
    cfg_data  = '0;
    for (int c = 0; c < CHANNELS; c++) level[c] = $urandom_range(0, SMP_MAX);
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed part, light idling on both sides
    gap_pct   = 30;
    stall_pct = 30;

    // reset settings: rails and alternating bit patterns
    send_beat(beat_of(0, 0, 0));
    send_beat(beat_of(SMP_MAX, SMP_MAX, SMP_MAX));
    send_beat(beat_of(SMP_MAX, SMP_MAX, SMP_MAX));
    send_beat(beat_of(SMP_MAX, 0, 512));
    send_beat(beat_of('h2AA, 'h155, SMP_MAX));
    send_beat(beat_of('h155, 'h2AA, 0));

    // full weight and full ranges: the average moves nearly all the way to the sample
    settle();
    set_all(16'hFFFF, 0, SMP_MAX, 0, 255);
    send_beat(beat_of(SMP_MAX, 0, 511));
    send_beat(beat_of(0, SMP_MAX, 1));
    send_beat(beat_of(SMP_MAX, SMP_MAX, 0));

    // zero weight: averages stay frozen
    settle();
    set_all(0, IN_LOW_RST, IN_HIGH_RST, OUT_LOW_RST, OUT_HIGH_RST);
    send_beat(beat_of(0, SMP_MAX, 500));
    send_beat(beat_of(SMP_MAX, 0, 0));

    // equal span ends: duty is out_low whatever the average
    settle();
    set_all(16'h8000, 500, 500, 77, 200);
    send_beat(beat_of(600, 100, 500));
    send_beat(beat_of(SMP_MAX, 0, 500));

    // both spans reversed
    settle();
    set_all(16'hFFFF, 900, 100, 250, 5);
    send_beat(beat_of(SMP_MAX, 0, 500));
    send_beat(beat_of(0, SMP_MAX, 950));
    send_beat(beat_of(100, 900, 50));

    // register data wider than the register: only the low bits count
    settle();
    set_all(16'hFFFF, 16'hFFFF, 16'hFC00, 16'h01FF, 16'hFF00);
    send_beat(beat_of(0, SMP_MAX, 512));
    send_beat(beat_of(SMP_MAX, 0, 300));

    // steep map: clamp at the top, then at the bottom
    settle();
    set_all(16'hFFFF, 0, 1, 0, 255);
    send_beat(beat_of(SMP_MAX, 0, 1));
    settle();
    set_all(16'hFFFF, 0, 1, 255, 0);
    send_beat(beat_of(SMP_MAX, SMP_MAX, 0));

    // random phases, each with its own register settings
    for (int p = 0; p < RAND_PHASES; p++) begin
      settle();
      case ($urandom_range(0, 4))
        0:       alpha = 16'hFFFF;
        1:       alpha = CFG_DATA_W'($urandom_range(0, 255));
        2:       alpha = ALPHA_RST;
        default: alpha = CFG_DATA_W'($urandom_range(0, 65535));
      endcase
      il = CFG_DATA_W'($urandom_range(0, SMP_MAX));
      ih = ($urandom_range(0, 7) == 0) ? il : CFG_DATA_W'($urandom_range(0, SMP_MAX));
      ol = CFG_DATA_W'($urandom_range(0, 255));
      oh = CFG_DATA_W'($urandom_range(0, 255));
      // now and then junk in the upper bits of a register write
      if ($urandom_range(0, 3) == 0) il = il | CFG_DATA_W'($urandom_range(0, 63) << IN_W);
      if ($urandom_range(0, 3) == 0) oh = oh | CFG_DATA_W'($urandom_range(0, 255) << DUTY_W);
      set_all(alpha, il, ih, ol, oh);

      // the last phase and one in the middle run with no idling at all
      if (p == 3 || p == RAND_PHASES - 1) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = $urandom_range(10, 60);
        stall_pct = $urandom_range(10, 60);
      end

      for (int n = 0; n < BEATS_PER_PHASE; n++) begin
        // receiver holds off while beats keep coming, so the input backs up
        if ((p == 2 || p == 5) && n == HOLD_AT) hold_req = 1'b1;
        if ($urandom_range(0, 3) == 0) begin
          // noise: any sample on any channel
          it = beat_of($urandom_range(0, SMP_MAX), $urandom_range(0, SMP_MAX),
                       $urandom_range(0, SMP_MAX));
        end else begin
          // pedal motion: each channel dwells near a level with a little jitter
          for (int c = 0; c < CHANNELS; c++) begin
            if ($urandom_range(0, 15) == 0) begin
              case ($urandom_range(0, 3))
                0:       level[c] = 0;
                1:       level[c] = SMP_MAX;
                default: level[c] = $urandom_range(0, SMP_MAX);
              endcase
            end
            v = level[c] + $urandom_range(0, 16) - 8;
            if (v < 0) v = 0;
            if (v > SMP_MAX) v = SMP_MAX;
            smp[c] = v;
          end
          it = beat_of(smp[0], smp[1], smp[2]);
        end
        send_beat(it);
      end
    end

    // drain and verdict
    in_valid = 1'b0;
    wait (pending == 0);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("pedal_ema_filter_pwm_map_tb: PASS");
    end else begin
      $display("pedal_ema_filter_pwm_map_tb: FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/pefpm_pkg.sv
hw/rtl/pefpm_seq.sv
hw/rtl/pefpm_datapath.sv
hw/rtl/pedal_ema_filter_pwm_map.sv
hw/rtl/pefpm_checker.sv
test/pedal_duty_checker.sv
test/pedal_ema_filter_pwm_map_tb.sv
